// ===== sv/sgi_pkg.sv =====
// Shared definitions for the segment intersection unit.
// Holds the default coordinate width and the result flag group; no dependencies.
package sgi_pkg;

  localparam int COORD_WIDTH = 32;

  // Result flags that travel beside the crossing point.
  typedef struct packed {
    logic found;
    logic ahead;
    logic on_both;
    logic on_first;
  } sgi_flags_t;

endpackage

// ===== sv/segment_intersection_unit.sv =====
// Segment intersection unit: takes the endpoints of lines A-B and C-D as signed
// fixed-point coordinates and returns whether they cross, whether r >= 0, whether the
// crossing lies on both segments or on the first, and the saturated crossing point.
// One item is accepted every cycle while in_stall is low. The pipeline is made of
// the five front stages, three scaling stages, one stage per quotient bit of the
// rounding division (COORD_WIDTH + 1 of them) and the final saturation stage.
// The whole pipeline advances together; it holds whenever a finished result waits
// on a stalled output, and in_stall is raised in exactly those cycles.
module segment_intersection_unit #(
  parameter int COORD_WIDTH = sgi_pkg::COORD_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_d_x,
  input  logic signed [COORD_WIDTH-1:0] in_d_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_found,
  output logic                          out_ahead,
  output logic                          out_on_both,
  output logic                          out_on_first,
  output logic signed [COORD_WIDTH-1:0] out_cross_x,
  output logic signed [COORD_WIDTH-1:0] out_cross_y
);

  localparam int CW  = COORD_WIDTH;
  localparam int QW  = 2 * CW + 3;
  localparam int FL  = 5;           // front end stages
  localparam int PL  = CW + 5;      // point stages
  localparam int LAT = FL + PL;

  logic en;
  logic vld_r [LAT];

  sgi_pkg::sgi_flags_t  f_flags;
  sgi_pkg::sgi_flags_t  fl_r [PL];
  logic                 f_qneg;
  logic [QW-1:0]        f_qmag, f_dmag;
  logic signed [CW-1:0] f_ax, f_ay, pt_x, pt_y;
  logic signed [CW:0]   f_abx, f_aby;

  // Everything moves unless a finished item is held at the output.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  sgi_front #(.CW(CW)) u_front (
    .clk     (clk),
    .en      (en),
    .a_x     (in_a_x),
    .a_y     (in_a_y),
    .b_x     (in_b_x),
    .b_y     (in_b_y),
    .c_x     (in_c_x),
    .c_y     (in_c_y),
    .d_x     (in_d_x),
    .d_y     (in_d_y),
    .flags_o (f_flags),
    .qneg_o  (f_qneg),
    .qmag_o  (f_qmag),
    .dmag_o  (f_dmag),
    .ax_o    (f_ax),
    .ay_o    (f_ay),
    .abx_o   (f_abx),
    .aby_o   (f_aby)
  );

  sgi_point #(.CW(CW)) u_point_x (
    .clk     (clk),
    .en      (en),
    .a_i     (f_ax),
    .delta_i (f_abx),
    .qneg_i  (f_qneg),
    .qmag_i  (f_qmag),
    .dmag_i  (f_dmag),
    .pt_o    (pt_x)
  );

  sgi_point #(.CW(CW)) u_point_y (
    .clk     (clk),
    .en      (en),
    .a_i     (f_ay),
    .delta_i (f_aby),
    .qneg_i  (f_qneg),
    .qmag_i  (f_qmag),
    .dmag_i  (f_dmag),
    .pt_o    (pt_y)
  );

  // Valid bits travel beside the data; only they need a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // The flags wait for the point division to finish.
  always_ff @(posedge clk) begin
    if (en) begin
      fl_r[0] <= f_flags;
      for (int k = 1; k < PL; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_found    = fl_r[PL-1].found;
  assign out_ahead    = fl_r[PL-1].ahead;
  assign out_on_both  = fl_r[PL-1].on_both;
  assign out_on_first = fl_r[PL-1].on_first;
  // Parallel lines report a zero point.
  assign out_cross_x  = fl_r[PL-1].found ? pt_x : '0;
  assign out_cross_y  = fl_r[PL-1].found ? pt_y : '0;

`ifndef SYNTHESIS
  a_both_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_on_both) |-> out_on_first)
    else $error("on_both without on_first");

  a_first_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_on_first) |-> out_ahead)
    else $error("on_first without ahead");

  a_parallel_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (!out_ahead && !out_on_first && !out_on_both))
    else $error("flags set on parallel lines");
`endif

endmodule

// ===== sv/sgi_front.sv =====
// Front end of the segment intersection unit: differences, cross products and flags.
// Five register stages; depends on sgi_pkg.
module sgi_front #(
  parameter int CW = sgi_pkg::COORD_WIDTH
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [CW-1:0]        a_x,
  input  logic signed [CW-1:0]        a_y,
  input  logic signed [CW-1:0]        b_x,
  input  logic signed [CW-1:0]        b_y,
  input  logic signed [CW-1:0]        c_x,
  input  logic signed [CW-1:0]        c_y,
  input  logic signed [CW-1:0]        d_x,
  input  logic signed [CW-1:0]        d_y,
  output sgi_pkg::sgi_flags_t         flags_o,
  output logic                        qneg_o,
  output logic [2*CW+2:0]             qmag_o,
  output logic [2*CW+2:0]             dmag_o,
  output logic signed [CW-1:0]        ax_o,
  output logic signed [CW-1:0]        ay_o,
  output logic signed [CW:0]          abx_o,
  output logic signed [CW:0]          aby_o
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int QW = PW + 1;

  // Stage 1: coordinate differences.
  logic signed [DW-1:0] abx1_r, aby1_r, cdx1_r, cdy1_r, acx1_r, acy1_r;
  logic signed [CW-1:0] ax1_r, ay1_r;
  // Stage 2: products.
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  logic signed [DW-1:0] abx2_r, aby2_r;
  logic signed [CW-1:0] ax2_r, ay2_r;
  // Stage 3: numerators and denominator.
  logic signed [QW-1:0] q3_r, s3_r, d3_r;
  logic signed [DW-1:0] abx3_r, aby3_r;
  logic signed [CW-1:0] ax3_r, ay3_r;
  // Stage 4: magnitudes and signs after the denominator is made positive.
  logic [QW-1:0]        qmag4_r, smag4_r, dmag4_r;
  logic                 qneg4_r, sneg4_r, found4_r;
  logic signed [DW-1:0] abx4_r, aby4_r;
  logic signed [CW-1:0] ax4_r, ay4_r;
  // Stage 5: flags.
  sgi_pkg::sgi_flags_t  flags5_r;
  logic                 qneg5_r;
  logic [QW-1:0]        qmag5_r, dmag5_r;
  logic signed [DW-1:0] abx5_r, aby5_r;
  logic signed [CW-1:0] ax5_r, ay5_r;

  logic dneg;
  logic rin, sin;

  assign dneg = d3_r[QW-1];
  assign rin  = !qneg4_r && (qmag4_r <= dmag4_r);
  assign sin  = !sneg4_r && (smag4_r <= dmag4_r);

  always_ff @(posedge clk) begin
    if (en) begin
      abx1_r <= $signed({b_x[CW-1], b_x}) - $signed({a_x[CW-1], a_x});
      aby1_r <= $signed({b_y[CW-1], b_y}) - $signed({a_y[CW-1], a_y});
      cdx1_r <= $signed({d_x[CW-1], d_x}) - $signed({c_x[CW-1], c_x});
      cdy1_r <= $signed({d_y[CW-1], d_y}) - $signed({c_y[CW-1], c_y});
      acx1_r <= $signed({a_x[CW-1], a_x}) - $signed({c_x[CW-1], c_x});
      acy1_r <= $signed({a_y[CW-1], a_y}) - $signed({c_y[CW-1], c_y});
      ax1_r  <= a_x;
      ay1_r  <= a_y;

      p0_r   <= PW'(acy1_r) * PW'(cdx1_r);
      p1_r   <= PW'(acx1_r) * PW'(cdy1_r);
      p2_r   <= PW'(acy1_r) * PW'(abx1_r);
      p3_r   <= PW'(acx1_r) * PW'(aby1_r);
      p4_r   <= PW'(abx1_r) * PW'(cdy1_r);
      p5_r   <= PW'(aby1_r) * PW'(cdx1_r);
      abx2_r <= abx1_r;
      aby2_r <= aby1_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;

      q3_r   <= $signed({p0_r[PW-1], p0_r}) - $signed({p1_r[PW-1], p1_r});
      s3_r   <= $signed({p2_r[PW-1], p2_r}) - $signed({p3_r[PW-1], p3_r});
      d3_r   <= $signed({p4_r[PW-1], p4_r}) - $signed({p5_r[PW-1], p5_r});
      abx3_r <= abx2_r;
      aby3_r <= aby2_r;
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;

      qmag4_r  <= q3_r[QW-1] ? $unsigned(-q3_r) : $unsigned(q3_r);
      smag4_r  <= s3_r[QW-1] ? $unsigned(-s3_r) : $unsigned(s3_r);
      dmag4_r  <= dneg ? $unsigned(-d3_r) : $unsigned(d3_r);
      qneg4_r  <= (q3_r != '0) && (q3_r[QW-1] ^ dneg);
      sneg4_r  <= (s3_r != '0) && (s3_r[QW-1] ^ dneg);
      found4_r <= (d3_r != '0);
      abx4_r   <= abx3_r;
      aby4_r   <= aby3_r;
      ax4_r    <= ax3_r;
      ay4_r    <= ay3_r;

      flags5_r.found    <= found4_r;
      flags5_r.ahead    <= found4_r && !qneg4_r;
      flags5_r.on_first <= found4_r && rin;
      flags5_r.on_both  <= found4_r && rin && sin;
      qneg5_r <= qneg4_r;
      qmag5_r <= qmag4_r;
      dmag5_r <= dmag4_r;
      abx5_r  <= abx4_r;
      aby5_r  <= aby4_r;
      ax5_r   <= ax4_r;
      ay5_r   <= ay4_r;
    end
  end

  assign flags_o = flags5_r;
  assign qneg_o  = qneg5_r;
  assign qmag_o  = qmag5_r;
  assign dmag_o  = dmag5_r;
  assign ax_o    = ax5_r;
  assign ay_o    = ay5_r;
  assign abx_o   = abx5_r;
  assign aby_o   = aby5_r;

endmodule

// ===== sv/sgi_div_step.sv =====
// One restoring division step: brings in one dividend bit, yields one quotient bit.
// Registered; no package dependencies.
module sgi_div_step #(
  parameter int EW = 68,
  parameter int QB = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [EW:0]   rem_i,
  input  logic [QB-1:0] nb_i,
  input  logic [QB-1:0] q_i,
  input  logic [EW-1:0] e_i,
  output logic [EW:0]   rem_o,
  output logic [QB-1:0] nb_o,
  output logic [QB-1:0] q_o,
  output logic [EW-1:0] e_o
);

  logic [EW:0]   rem_r;
  logic [QB-1:0] nb_r, q_r;
  logic [EW-1:0] e_r;
  logic [EW:0]   t;
  logic          ge;

  assign t  = {rem_i[EW-1:0], nb_i[QB-1]};
  assign ge = (t >= {1'b0, e_i});

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? (t - {1'b0, e_i}) : t;
      nb_r  <= {nb_i[QB-2:0], 1'b0};
      q_r   <= {q_i[QB-2:0], ge};
      e_r   <= e_i;
    end
  end

  assign rem_o = rem_r;
  assign nb_o  = nb_r;
  assign q_o   = q_r;
  assign e_o   = e_r;

endmodule

// ===== sv/sgi_point.sv =====
// Crossing point of one axis: A + round(r * delta), saturated.
// Multiply, scale, then one quotient bit per stage; uses sgi_div_step and sgi_pkg.
module sgi_point #(
  parameter int CW = sgi_pkg::COORD_WIDTH
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] a_i,
  input  logic signed [CW:0]   delta_i,
  input  logic                 qneg_i,
  input  logic [2*CW+2:0]      qmag_i,
  input  logic [2*CW+2:0]      dmag_i,
  output logic signed [CW-1:0] pt_o
);

  localparam int DW   = CW + 1;
  localparam int QW   = 2 * DW + 1;
  localparam int LO   = (QW + 1) / 2;
  localparam int HI   = QW - LO;
  localparam int NUMW = QW + DW;
  localparam int NW   = NUMW + 2;
  localparam int EW   = QW + 1;
  localparam int RW   = EW + 1;
  localparam int QB   = CW + 1;
  localparam int SW   = CW + 3;
  localparam logic signed [SW-1:0] HI_S = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] LO_S = ~HI_S;

  logic [DW-1:0]        dm;
  logic [LO+DW-1:0]     pplo1_r;
  logic [HI+DW-1:0]     pphi1_r;
  logic [QW-1:0]        dmag1_r;
  logic signed [CW-1:0] a1_r, a2_r;
  logic                 neg1_r, neg2_r;
  logic [NUMW-1:0]      num;
  logic [NW-1:0]        n2_r;
  logic [EW-1:0]        e2_r;
  logic [RW-1:0]        rem0;

  logic [RW-1:0]        rem_w [QB+1];
  logic [QB-1:0]        nb_w  [QB+1];
  logic [QB-1:0]        q_w   [QB+1];
  logic [EW-1:0]        e_w   [QB+1];
  logic signed [CW-1:0] a_r   [QB+1];
  logic                 neg_r [QB+1];
  logic                 big_r [QB+1];

  logic [RW-1:0]        rem3_r;
  logic [QB-1:0]        nb3_r;
  logic [EW-1:0]        e3_r;

  logic signed [SW-1:0] ae, me, sum;
  logic signed [CW-1:0] pt_r;

  assign dm   = delta_i[DW-1] ? $unsigned(-delta_i) : $unsigned(delta_i);
  assign num  = {pphi1_r, {LO{1'b0}}} + NUMW'(pplo1_r);
  assign rem0 = RW'(n2_r >> QB);

  always_ff @(posedge clk) begin
    if (en) begin
      pplo1_r <= (LO+DW)'(qmag_i[LO-1:0]) * (LO+DW)'(dm);
      pphi1_r <= (HI+DW)'(qmag_i[QW-1:LO]) * (HI+DW)'(dm);
      dmag1_r <= dmag_i;
      a1_r    <= a_i;
      neg1_r  <= qneg_i ^ delta_i[DW-1];

      // Rounded quotient is floor((2*num + D) / (2*D)).
      n2_r   <= NW'({num, 1'b0}) + NW'(dmag1_r);
      e2_r   <= {dmag1_r, 1'b0};
      a2_r   <= a1_r;
      neg2_r <= neg1_r;

      rem3_r   <= rem0;
      nb3_r    <= n2_r[QB-1:0];
      e3_r     <= e2_r;
      a_r[0]   <= a2_r;
      neg_r[0] <= neg2_r;
      big_r[0] <= (rem0 >= {1'b0, e2_r});
      for (int k = 0; k < QB; k++) begin
        a_r[k+1]   <= a_r[k];
        neg_r[k+1] <= neg_r[k];
        big_r[k+1] <= big_r[k];
      end
    end
  end

  assign rem_w[0] = rem3_r;
  assign nb_w[0]  = nb3_r;
  assign q_w[0]   = '0;
  assign e_w[0]   = e3_r;

  for (genvar i = 0; i < QB; i++) begin : g_step
    sgi_div_step #(.EW(EW), .QB(QB)) u_step (
      .clk   (clk),
      .en    (en),
      .rem_i (rem_w[i]),
      .nb_i  (nb_w[i]),
      .q_i   (q_w[i]),
      .e_i   (e_w[i]),
      .rem_o (rem_w[i+1]),
      .nb_o  (nb_w[i+1]),
      .q_o   (q_w[i+1]),
      .e_o   (e_w[i+1])
    );
  end

  assign ae  = {{(SW-CW){a_r[QB][CW-1]}}, a_r[QB]};
  assign me  = $signed({2'b00, q_w[QB]});
  assign sum = neg_r[QB] ? (ae - me) : (ae + me);

  always_ff @(posedge clk) begin
    if (en) begin
      if (big_r[QB]) begin
        pt_r <= neg_r[QB] ? LO_S[CW-1:0] : HI_S[CW-1:0];
      end else if (sum > HI_S) begin
        pt_r <= HI_S[CW-1:0];
      end else if (sum < LO_S) begin
        pt_r <= LO_S[CW-1:0];
      end else begin
        pt_r <= sum[CW-1:0];
      end
    end
  end

  assign pt_o = pt_r;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for segment_intersection_unit.
// Depends on sgi_pkg and the unit; an internal predictor computes every expected result not typed into the table.
module testbench;

  localparam int CW        = sgi_pkg::COORD_WIDTH;
  localparam int N_RANDOM  = 1150;
  localparam int DRAIN     = CW + 30;
  localparam int IDLE_MAX  = 3000;
  localparam logic signed [CW-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [CW-1:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;

  typedef struct {
    logic signed [CW-1:0] a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
  } seg_pair_t;

  typedef struct {
    sgi_pkg::sgi_flags_t  flags;
    logic signed [CW-1:0] cross_x, cross_y;
  } crossing_t;

  typedef struct {
    seg_pair_t pair;
    bit        typed;
    crossing_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] in_a_x = '0, in_a_y = '0, in_b_x = '0, in_b_y = '0;
  logic signed [CW-1:0] in_c_x = '0, in_c_y = '0, in_d_x = '0, in_d_y = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic out_found, out_ahead, out_on_both, out_on_first;
  logic signed [CW-1:0] out_cross_x, out_cross_y;

  stim_row_t  stim[$];
  crossing_t  pending[$];
  int         next_idx = 0;
  int         n_items  = 0;
  int         errors   = 0;
  int         quiet    = 0;
  int         pause_at = 0;
  bit         paused   = 1'b0;
  bit         all_sent = 1'b0;

  always #1 clk = ~clk;

  segment_intersection_unit dut (.*);

  // One axis of the crossing point: A plus the rounded offset r*delta, saturated.
  function automatic logic signed [CW-1:0] point_axis(logic signed [127:0] a,
      logic signed [127:0] delta, logic signed [127:0] qr, logic signed [127:0] dn);
    logic [127:0] num, quot;
    logic signed [127:0] v;
    bit neg;
    neg  = (qr < 0) != (delta < 0);
    num  = (qr < 0 ? -qr : qr) * (delta < 0 ? -delta : delta);
    quot = (2 * num + dn) / (2 * dn);
    if (quot >= (128'd1 << 62)) return neg ? CMIN : CMAX;
    v = neg ? a - $signed(quot) : a + $signed(quot);
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v[CW-1:0];
  endfunction

  // Exact wide-integer prediction of one result from one item.
  function automatic crossing_t predict_crossing(seg_pair_t p);
    logic signed [127:0] ax, ay, abx, aby, cdx, cdy, acx, acy, qr, qs, dn;
    crossing_t r;
    bit rin, sin;
    ax  = 128'(p.a_x);
    ay  = 128'(p.a_y);
    abx = 128'(p.b_x) - ax;
    aby = 128'(p.b_y) - ay;
    cdx = 128'(p.d_x) - 128'(p.c_x);
    cdy = 128'(p.d_y) - 128'(p.c_y);
    acx = ax - 128'(p.c_x);
    acy = ay - 128'(p.c_y);
    qr  = acy * cdx - acx * cdy;
    qs  = acy * abx - acx * aby;
    dn  = abx * cdy - aby * cdx;
    r = '{flags: '0, cross_x: '0, cross_y: '0};
    if (dn == 0) return r;
    if (dn < 0) begin
      dn = -dn;
      qr = -qr;
      qs = -qs;
    end
    rin = (qr >= 0) && (qr <= dn);
    sin = (qs >= 0) && (qs <= dn);
    r.flags.found    = 1'b1;
    r.flags.ahead    = qr >= 0;
    r.flags.on_both  = rin && sin;
    r.flags.on_first = rin;
    r.cross_x = point_axis(ax, abx, qr, dn);
    r.cross_y = point_axis(ay, aby, qr, dn);
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    return $signed($urandom());
  endfunction

  // Small coordinates within a few units of the origin, so crossings often land on segments.
  function automatic logic signed [CW-1:0] near_coord();
    return $signed($urandom_range(0, 8 << 16)) - (4 <<< 16);
  endfunction

  function automatic logic signed [CW-1:0] edge_coord();
    case ($urandom_range(0, 3))
      0: return CMAX - $urandom_range(0, 3);
      1: return CMIN + $urandom_range(0, 3);
      2: return $signed($urandom_range(0, 6)) - 3;
      default: return rand_coord();
    endcase
  endfunction

  task automatic add_row(logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy,
                         bit typed = 0, crossing_t res = '{'0, '0, '0});
    stim_row_t s;
    s.pair  = '{ax, ay, bx, by, cx, cy, dx, dy};
    s.typed = typed;
    s.res   = res;
    stim.push_back(s);
  endtask

  task automatic build_stimulus();
    seg_pair_t p;
    int k;
    // Directed table. Rows with a typed result: parallel or degenerate lines give all
    // zero fields, and the crossing of two unit diagonals is plainly at (1, 1).
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 1);
    add_row(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 1);
    add_row(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 1);
    add_row(0, 0, 2 * ONE, 0, 0, ONE, 2 * ONE, ONE, 1);
    add_row(CMIN, CMIN, CMAX, CMAX, CMIN, CMIN + 1, CMAX, CMAX + 0, 0);
    add_row(0, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE, 0, 1,
            '{4'b1111, ONE, ONE});
    // The rest go through the predictor: extremes, saturation, r below zero or above one,
    // endpoints that touch, and halfway rounding ties.
    add_row(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
    add_row(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);
    add_row(0, 0, 1, 0, CMAX, CMIN, CMAX, CMAX);
    add_row(0, 0, -1, 0, CMIN, CMIN, CMIN, CMAX);
    add_row(CMAX, 0, CMAX - 1, 1, 0, CMIN, 0, CMAX);
    add_row(0, 0, ONE, 0, 3 * ONE, -ONE, 3 * ONE, ONE);
    add_row(0, 0, ONE, 0, -3 * ONE, -ONE, -3 * ONE, ONE);
    add_row(0, 0, ONE, 0, ONE, -ONE, ONE, ONE);
    add_row(0, 0, ONE, 0, 0, 0, 0, ONE);
    add_row(0, 0, ONE, ONE, 2 * ONE, 0, 2 * ONE, 5 * ONE);
    add_row(0, 0, 3, 0, 1, -1, 1, 1);
    add_row(0, 0, -3, 0, -1, -1, -1, 1);
    add_row(0, 0, 1, 0, 0, 0, 0, 1);
    add_row(0, 0, 5, 3, 2, 0, 1, 7);
    add_row(-1, -1, CMAX, 0, 0, CMIN, 1, CMAX);
    add_row(CMAX, CMAX, CMIN, CMIN, 0, ONE, ONE, 0);
    for (k = 0; k < N_RANDOM; k++) begin
      case ($urandom_range(0, 9))
        0, 1: p = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord()};
        2: p = '{edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                 edge_coord(), edge_coord(), edge_coord(), edge_coord()};
        3: begin
          // Parallel pair: C-D is the direction of A-B moved somewhere else.
          p.a_x = near_coord(); p.a_y = near_coord();
          p.b_x = near_coord(); p.b_y = near_coord();
          p.c_x = near_coord(); p.c_y = near_coord();
          p.d_x = p.c_x + (p.b_x - p.a_x);
          p.d_y = p.c_y + (p.b_y - p.a_y);
        end
        default: p = '{near_coord(), near_coord(), near_coord(), near_coord(),
                       near_coord(), near_coord(), near_coord(), near_coord()};
      endcase
      add_row(p.a_x, p.a_y, p.b_x, p.b_y, p.c_x, p.c_y, p.d_x, p.d_y);
    end
    n_items  = stim.size();
    pause_at = n_items / 2;
  endtask

  // Idle odds per phase: the first third stalls the receiver most, the second idles the sender most.
  function automatic bit sender_idles(int idx);
    if (idx < n_items / 3) return $urandom_range(0, 99) < 35;
    if (idx < 2 * n_items / 3) return $urandom_range(0, 99) < 63;
    return 1'b0;
  endfunction

  function automatic bit receiver_stalls(int idx);
    if (idx < n_items / 3) return $urandom_range(0, 99) < 63;
    if (idx < 2 * n_items / 3) return $urandom_range(0, 99) < 35;
    return 1'b0;
  endfunction

  // Sender. An accepted item is predicted at the edge that takes it; a stalled item
  // holds, and once at mid-run the sender waits until every pending result is out.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (stim[next_idx].typed) pending.push_back(stim[next_idx].res);
        else pending.push_back(predict_crossing(stim[next_idx].pair));
        next_idx++;
        if (next_idx == n_items) all_sent = 1'b1;
      end
      if (!(in_valid && in_stall)) begin
        if (next_idx == pause_at && !paused && pending.size() != 0) begin
          in_valid <= 1'b0;
        end else if (next_idx < n_items && !sender_idles(next_idx)) begin
          if (next_idx == pause_at) paused = 1'b1;
          in_valid <= 1'b1;
          in_a_x <= stim[next_idx].pair.a_x;
          in_a_y <= stim[next_idx].pair.a_y;
          in_b_x <= stim[next_idx].pair.b_x;
          in_b_y <= stim[next_idx].pair.b_y;
          in_c_x <= stim[next_idx].pair.c_x;
          in_c_y <= stim[next_idx].pair.c_y;
          in_d_x <= stim[next_idx].pair.d_x;
          in_d_y <= stim[next_idx].pair.d_y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result against the oldest pending one.
  always @(posedge clk) begin
    crossing_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          $error("result arrived with nothing pending");
          errors++;
        end else begin
          e = pending.pop_front();
          if (out_found !== e.flags.found) begin
            $error("found: expected %0b, got %0b", e.flags.found, out_found);
            errors++;
          end
          if (out_ahead !== e.flags.ahead) begin
            $error("ahead: expected %0b, got %0b", e.flags.ahead, out_ahead);
            errors++;
          end
          if (out_on_both !== e.flags.on_both) begin
            $error("on_both: expected %0b, got %0b", e.flags.on_both, out_on_both);
            errors++;
          end
          if (out_on_first !== e.flags.on_first) begin
            $error("on_first: expected %0b, got %0b", e.flags.on_first, out_on_first);
            errors++;
          end
          if (out_cross_x !== e.cross_x) begin
            $error("cross_x: expected %h, got %h", e.cross_x, out_cross_x);
            errors++;
          end
          if (out_cross_y !== e.cross_y) begin
            $error("cross_y: expected %h, got %h", e.cross_y, out_cross_y);
            errors++;
          end
        end
      end
      out_stall <= receiver_stalls(next_idx);
    end
  end

  // Watchdog on cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= IDLE_MAX) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (all_sent && pending.size() == 0);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
